>>> rtl/core/ir_ac_frame_pulse_sequencer_assert.svh
// Assertion macros for the frame pulse sequencer.
// Each macro checks on the rising edge of clk and is off while rst_n is low.
`ifndef IR_AC_FRAME_PULSE_SEQUENCER_ASSERT_SVH
`define IR_AC_FRAME_PULSE_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge out of reset.
`define IRAC_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("ir_ac_frame_pulse_sequencer: assertion failed");

// Consequence must hold in the cycle after the trigger.
`define IRAC_ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("ir_ac_frame_pulse_sequencer: assertion failed");

`else

`define IRAC_ASSERT(lbl, cond)
`define IRAC_ASSERT_NEXT(lbl, trig, cons)

`endif

`endif

>>> rtl/core/iracfps_pkg.sv
package iracfps_pkg;

  // Store and frame geometry
  localparam int STATE_BYTES = 16;
  localparam int BYTE_IDX_W  = 4;
  localparam int POS_W       = 9;
  localparam int Q_W         = 8;
  localparam int TICK_W      = 9;

  localparam logic [POS_W-1:0] HALF_PULSES = 9'd140;
  localparam logic [POS_W-1:0] PASS_LAST   = 9'd279;

  // Pulse positions within one half
  localparam logic [Q_W-1:0] Q_HDR_MARK   = 8'd0;
  localparam logic [Q_W-1:0] Q_HDR_SPACE  = 8'd1;
  localparam logic [Q_W-1:0] Q_CMD_FIRST  = 8'd2;
  localparam logic [Q_W-1:0] Q_CMD_LAST   = 8'd65;
  localparam logic [Q_W-1:0] Q_FTR_FIRST  = 8'd66;
  localparam logic [Q_W-1:0] Q_FTR_LAST   = 8'd71;
  localparam logic [Q_W-1:0] Q_GAP_MARK   = 8'd72;
  localparam logic [Q_W-1:0] Q_GAP_SPACE  = 8'd73;
  localparam logic [Q_W-1:0] Q_DAT_FIRST  = 8'd74;
  localparam logic [Q_W-1:0] Q_DAT_LAST   = 8'd137;
  localparam logic [Q_W-1:0] Q_END_MARK   = 8'd138;

  // Durations in ticks
  localparam logic [TICK_W-1:0] T_HDR_MARK  = 9'd106;
  localparam logic [TICK_W-1:0] T_HDR_SPACE = 9'd53;
  localparam logic [TICK_W-1:0] T_BIT_MARK  = 9'd8;
  localparam logic [TICK_W-1:0] T_ONE_SPACE = 9'd18;
  localparam logic [TICK_W-1:0] T_ZERO_SPC  = 9'd6;
  localparam logic [TICK_W-1:0] T_GAP       = 9'd235;
  localparam logic [TICK_W-1:0] T_DBL_GAP   = 9'd470;

  // Footer value and checksum seed
  localparam logic [1:0] FOOTER_ONE_BIT = 2'd1;
  localparam logic [3:0] CS_SEED        = 4'd10;
  localparam logic [2:0] CS_BYTE_SLOT   = 3'd7;

  localparam logic [16:0] DUR_MAX = 17'd65535;

  // Register reset values
  localparam logic [7:0] TICK_US_RESET = 8'd85;
  localparam logic [3:0] REPEAT_RESET  = 4'd0;

  // Configuration register indexes
  typedef enum logic {
    REG_TICK_US = 1'b0,
    REG_REPEAT  = 1'b1
  } cfg_reg_t;

  // Request codes
  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_PULSE = 1'b1
  } req_t;

endpackage

>>> rtl/core/ir_ac_frame_pulse_sequencer.sv
// Pulse-distance IR frame sequencer for a 16-byte air-conditioner state.
// Input channel (in_valid/in_ready): an item either loads one state byte
// (in_req_type = load) or asks for the next pulse of the frame (pulse).
// Loads arriving while a frame is in progress are dropped.
// Result channel (out_valid/out_ready): one item per pulse request, giving
// the level, the length in microseconds (saturated at 65535) and a last flag
// on the closing gap of the final repetition. Loads produce no result.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 = tick_us, 1 = repeat_count); write only while the block is idle.
// Path: an accepted request goes into the input register, then through
// decode and the 9x8 multiply into the result register.
// Throughput: one item per cycle while the receiver does not stall, set by the
// single decode/multiply stage. When the receiver stalls, the result register
// holds and the input register fills; in_ready drops only while both are occupied.
// Reset (rst_n low, synchronous) empties both registers, rewinds the frame
// position and repeat counter, and sets tick_us to 85 and repeat_count to 0.
// State bytes are not cleared and must be loaded before the first frame.
`include "ir_ac_frame_pulse_sequencer_assert.svh"

module ir_ac_frame_pulse_sequencer
  import iracfps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [3:0]  in_byte_index,
  input  logic [7:0]  in_byte_value,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_level,
  output logic [15:0] out_duration_us,
  output logic        out_last
);

  // Registers
  logic [7:0]            tick_us_r;
  logic [3:0]            repeat_r;
  logic [7:0]            store_r [STATE_BYTES];
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [3:0]            pass_r, pass_nxt;
  logic                  busy_r, busy_nxt;

  logic                  s1_valid_r;
  logic                  s1_req_r;
  logic [BYTE_IDX_W-1:0] s1_idx_r;
  logic [7:0]            s1_val_r;

  logic                  out_valid_r;
  logic                  out_level_r, out_level_nxt;
  logic [15:0]           out_dur_r, out_dur_nxt;
  logic                  out_last_r, out_last_nxt;

  // Stage control
  logic advance, s1_pulse, in_accept;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign s1_pulse  = (s1_req_r == REQ_PULSE);
  assign in_ready  = !s1_valid_r || advance;
  assign in_accept = in_valid && in_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_us_r <= TICK_US_RESET;
      repeat_r  <= REPEAT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TICK_US: tick_us_r <= cfg_data;
        REG_REPEAT:  repeat_r  <= cfg_data[3:0];
        default:     ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req_r <= in_req_type;
      s1_idx_r <= in_byte_index;
      s1_val_r <= in_byte_value;
    end
  end

  // State byte store, written only between frames
  always_ff @(posedge clk) begin
    if (advance && !s1_pulse && !busy_r) begin
      store_r[s1_idx_r] <= s1_val_r;
    end
  end

  // Checksums of both halves from their fixed byte positions
  logic [3:0] cs0, cs1;

  assign cs0 = CS_SEED + store_r[0][3:0] + store_r[1][3:0] + store_r[2][3:0]
             + store_r[3][3:0] + store_r[4][7:4] + store_r[5][7:4] + store_r[6][7:4];
  assign cs1 = CS_SEED + store_r[0][3:0] + store_r[1][3:0] + store_r[2][3:0]
             + store_r[11][3:0] + store_r[12][7:4] + store_r[13][7:4]
             + store_r[14][7:4];

  // Decode the current pulse position
  logic                  half;
  logic [Q_W-1:0]        q, k;
  logic                  in_data;
  logic [BYTE_IDX_W-1:0] frame_idx, phys_idx;
  logic [7:0]            raw_byte, sent_byte;
  logic                  data_bit, footer_bit;
  logic                  lvl;
  logic [TICK_W-1:0]     ticks;
  logic [16:0]           dur_full;

  assign half     = (pos_r >= HALF_PULSES);
  assign q        = half ? Q_W'(pos_r - HALF_PULSES) : pos_r[Q_W-1:0];
  assign in_data  = (q >= Q_DAT_FIRST);
  assign k        = in_data ? (q - Q_DAT_FIRST) : (q - Q_CMD_FIRST);

  // Byte as sent: copies for bytes 8 to 10, checksum in the top nibble of 7 and 15
  assign frame_idx = {half, in_data, k[5:4]};
  assign phys_idx  = (frame_idx >= 4'd8 && frame_idx <= 4'd10)
                   ? {1'b0, frame_idx[2:0]} : frame_idx;
  assign raw_byte  = store_r[phys_idx];
  assign sent_byte = (frame_idx[2:0] == CS_BYTE_SLOT)
                   ? {(half ? cs1 : cs0), raw_byte[3:0]} : raw_byte;
  assign data_bit  = sent_byte[k[3:1]];

  // Footer value 2: only its middle bit is a one
  logic [Q_W-1:0] fk;
  assign fk         = q - Q_FTR_FIRST;
  assign footer_bit = (fk[2:1] == FOOTER_ONE_BIT);

  always_comb begin
    lvl   = 1'b0;
    ticks = T_DBL_GAP;
    case (q) inside
      Q_HDR_MARK: begin
        lvl   = 1'b1;
        ticks = T_HDR_MARK;
      end
      Q_HDR_SPACE: begin
        lvl   = 1'b0;
        ticks = T_HDR_SPACE;
      end
      [Q_CMD_FIRST:Q_CMD_LAST], [Q_DAT_FIRST:Q_DAT_LAST]: begin
        lvl   = !q[0];
        ticks = !q[0] ? T_BIT_MARK : (data_bit ? T_ONE_SPACE : T_ZERO_SPC);
      end
      [Q_FTR_FIRST:Q_FTR_LAST]: begin
        lvl   = !q[0];
        ticks = !q[0] ? T_BIT_MARK : (footer_bit ? T_ONE_SPACE : T_ZERO_SPC);
      end
      Q_GAP_MARK, Q_END_MARK: begin
        lvl   = 1'b1;
        ticks = T_BIT_MARK;
      end
      Q_GAP_SPACE: begin
        lvl   = 1'b0;
        ticks = T_GAP;
      end
      default: begin
        lvl   = 1'b0;
        ticks = T_DBL_GAP;
      end
    endcase
  end

  // Scale to microseconds (saturated below when forming the result)
  assign dur_full = 17'(ticks) * 17'(tick_us_r);

  // Advance frame position and repetition count
  always_comb begin
    pos_nxt       = pos_r;
    pass_nxt      = pass_r;
    busy_nxt      = busy_r;
    out_last_nxt  = 1'b0;
    out_level_nxt = lvl;
    out_dur_nxt   = (dur_full > DUR_MAX) ? 16'hFFFF : dur_full[15:0];
    if (advance && s1_pulse) begin
      busy_nxt = 1'b1;
      if (pos_r == PASS_LAST) begin
        pos_nxt = '0;
        if (pass_r >= repeat_r) begin
          out_last_nxt = 1'b1;
          pass_nxt     = '0;
          busy_nxt     = 1'b0;
        end else begin
          pass_nxt = pass_r + 4'd1;
        end
      end else begin
        pos_nxt = pos_r + 9'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      pass_r <= '0;
      busy_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      pass_r <= pass_nxt;
      busy_r <= busy_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_pulse;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_pulse) begin
      out_level_r <= out_level_nxt;
      out_dur_r   <= out_dur_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_level       = out_level_r;
  assign out_duration_us = out_dur_r;
  assign out_last        = out_last_r;

  // Checks
  `IRAC_ASSERT(a_idle_rewound, busy_r || (pos_r == '0 && pass_r == '0))
  `IRAC_ASSERT(a_pos_in_pass, pos_r <= PASS_LAST)
  `IRAC_ASSERT_NEXT(a_last_ends_frame, advance && s1_pulse && out_last_nxt, !busy_r && out_last)
  `IRAC_ASSERT_NEXT(a_pulse_gives_result, advance && s1_pulse, out_valid)

endmodule
